// ----- rtl/rps_pkg.sv -----
package rps_pkg;

	typedef enum logic [2:0] {
		REQ_TICK,
		REQ_PREEMPT,
		REQ_YIELD,
		REQ_BLOCK,
		REQ_WAKE,
		REQ_READY,
		REQ_RAISE
	} req_code_t;

	localparam logic [2:0] CFG_AGING_EN     = 3'd0;
	localparam logic [2:0] CFG_AGING_PERIOD = 3'd1;
	localparam logic [2:0] CFG_AGING_LIMIT  = 3'd2;
	localparam logic [2:0] CFG_ROUND_ROBIN  = 3'd3;
	localparam logic [2:0] CFG_TICK_START   = 3'd4;

	localparam logic [15:0] WAIT_FOREVER     = 16'hFFFF;
	localparam logic [15:0] AGING_PERIOD_RST = 16'd16;
	localparam logic [7:0]  AGING_LIMIT_RST  = 8'd128;

	typedef enum logic [1:0] {
		ST_DORMANT,
		ST_READY,
		ST_RUNNING,
		ST_BLOCKED
	} task_st_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  task_id;
		logic [2:0]  queue_id;
		logic [15:0] timeout;
		logic [7:0]  new_priority;
		logic [7:0]  wake_result;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  running_task;
		logic        switched;
		logic [7:0]  resume_result;
		logic        block_refused;
		logic [15:0] tick_now;
	} rsp_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_TICK_INC,
		CMD_WAKE_HEAD,
		CMD_AGE_SETTLE,
		CMD_AGE_PASS,
		CMD_SCHED_INS,
		CMD_DISPATCH,
		CMD_BLOCK,
		CMD_WAKE,
		CMD_MAKE_READY,
		CMD_RAISE,
		CMD_RQ_INS
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       timer_due;
		logic       aging_en;
		logic       age_zero;
		logic       preempt;
		logic       block_ok;
		logic       requeue;
	} dp_status_t;

endpackage

// ----- rtl/rps_if.sv -----
interface rps_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/rtos_priority_scheduler.sv -----
// Priority-preemptive task scheduler. Requests arrive as transactions on the
// req channel and each one yields exactly one transaction on the rsp channel,
// reporting the task running afterwards, whether a switch happened, its stored
// wake result, whether a block was refused and the tick counter.
// Configuration registers take effect on the next request; the user must
// write them through cfg_we, cfg_index and cfg_data only while no request is
// in flight; the block does not enforce this. One request is handled at a time.
// It is decoded after the accepting edge. Wake, make ready, unknown requests
// and a raise that leaves the ready queue alone then present their result; a
// raise that reorders it first reinserts the task, a preempt check or yield
// first runs the scheduling check and a block first tries to block the running
// task, and a switch adds a dispatch of the ready-queue head. A tick bumps the
// counter, wakes each task whose timer expires, settles the running priority
// and counts down the aging period if aging is enabled, runs an aging pass when
// it ends, then the scheduling check. The controller does one queue operation
// per cycle and returns to idle before accepting the next request. A stalled
// receiver holds the block in its final state until the output register frees up.
// Reset makes the idle task (slot 0) run, all other slots dormant, empties
// every queue and returns the registers to their defaults.
module rtos_priority_scheduler import rps_pkg::*; #(
	parameter int NUM_TASKS = 8,
	parameter int TICK_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rps_if.sink         req,
	rps_if.source       rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	rsp_item_t  result;
	rsp_item_t  rsp_data_q;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	rps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.out_free (out_free),
		.status   (status),
		.in_ready (req.ready),
		.cmd      (cmd)
	);

	rps_datapath #(
		.NUM_TASKS (NUM_TASKS),
		.TICK_BITS (TICK_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_in    (req.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) rsp_data_q <= result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a previous one is in progress");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp.valid)
		else $error("stored result not presented");

	a_refused_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.block_refused |-> !rsp.data.switched)
		else $error("refused block reported a switch");

endmodule

// ----- rtl/rps_ctrl.sv -----
module rps_ctrl import rps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_free,
	input  dp_status_t status,
	output logic       in_ready,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_TICK,
		S_TIMER,
		S_AGE_SETTLE,
		S_AGE_PASS,
		S_SCHED,
		S_DISPATCH,
		S_BLOCK,
		S_RQ_INS,
		S_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = CMD_NONE;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.op = CMD_LOAD;
			end
			S_DECODE: begin
				case (status.req_type)
					REQ_WAKE:  cmd.op = CMD_WAKE;
					REQ_READY: cmd.op = CMD_MAKE_READY;
					REQ_RAISE: cmd.op = CMD_RAISE;
					default:   cmd.op = CMD_NONE;
				endcase
			end
			S_TICK:       cmd.op = CMD_TICK_INC;
			S_TIMER: begin
				if (status.timer_due) cmd.op = CMD_WAKE_HEAD;
			end
			S_AGE_SETTLE: cmd.op = CMD_AGE_SETTLE;
			S_AGE_PASS:   cmd.op = CMD_AGE_PASS;
			S_SCHED: begin
				if (status.preempt) cmd.op = CMD_SCHED_INS;
			end
			S_DISPATCH:   cmd.op = CMD_DISPATCH;
			S_BLOCK:      cmd.op = CMD_BLOCK;
			S_RQ_INS:     cmd.op = CMD_RQ_INS;
			S_DONE:       cmd.out_load = out_free;
			default:      cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					case (status.req_type)
						REQ_TICK:    state_q <= S_TICK;
						REQ_PREEMPT: state_q <= S_SCHED;
						REQ_YIELD:   state_q <= S_SCHED;
						REQ_BLOCK:   state_q <= S_BLOCK;
						REQ_RAISE:   state_q <= status.requeue ? S_RQ_INS : S_DONE;
						default:     state_q <= S_DONE;
					endcase
				end
				S_TICK: state_q <= S_TIMER;
				S_TIMER: begin
					if (!status.timer_due) begin
						state_q <= status.aging_en ? S_AGE_SETTLE : S_SCHED;
					end
				end
				S_AGE_SETTLE: state_q <= status.age_zero ? S_AGE_PASS : S_SCHED;
				S_AGE_PASS:   state_q <= S_SCHED;
				S_SCHED:      state_q <= status.preempt ? S_DISPATCH : S_DONE;
				S_BLOCK:      state_q <= status.block_ok ? S_DISPATCH : S_DONE;
				S_DISPATCH:   state_q <= S_DONE;
				S_RQ_INS:     state_q <= S_DONE;
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/rps_datapath.sv -----
module rps_datapath import rps_pkg::*; #(
	parameter int NUM_TASKS = 8,
	parameter int TICK_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  req_item_t   req_in,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output dp_status_t  status,
	output rsp_item_t   result
);

	localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CW = $clog2(NUM_TASKS + 1);
	localparam int TB = TICK_BITS;

	logic            aging_en_q;
	logic [15:0]     period_q;
	logic [7:0]      limit_q;
	logic            rr_q;

	req_item_t       req_q;
	logic [SW-1:0]   before_q;
	logic            refused_q;

	logic [SW-1:0]   cur_q;
	logic [TB-1:0]   counter_q;
	logic [15:0]     agecnt_q;
	logic [7:0]      prio_q [NUM_TASKS];
	logic [7:0]      base_q [NUM_TASKS];
	task_st_t        st_q [NUM_TASKS];
	logic            timed_q [NUM_TASKS];
	logic [TB-1:0]   wake_q [NUM_TASKS];
	logic [7:0]      res_q [NUM_TASKS];
	logic [SW-1:0]   rdy_q [NUM_TASKS];
	logic [CW-1:0]   rdy_n_q;
	logic [SW-1:0]   tmr_q [NUM_TASKS];
	logic [CW-1:0]   tmr_n_q;

	logic [SW-1:0]   slot_req;
	logic            tid_ok;
	task_st_t        req_st;
	logic [SW-1:0]   head;
	logic            rdy_nz;
	logic            ycur;
	logic [7:0]      settled;
	logic            preempt;
	logic            block_ok;
	logic            wake_ok;
	logic            ready_ok;
	logic            raise_ok;

	logic [SW-1:0]   ins_slot;
	logic [7:0]      ins_key;
	logic [CW-1:0]   ins_pos;
	logic [SW-1:0]   rdy_ins [NUM_TASKS];
	logic [SW-1:0]   rm_slot;
	logic [CW-1:0]   rm_pos;
	logic [SW-1:0]   rdy_rm [NUM_TASKS];
	logic [CW-1:0]   tins_pos;
	logic [SW-1:0]   tmr_ins [NUM_TASKS];
	logic [SW-1:0]   trm_slot;
	logic [CW-1:0]   trm_pos;
	logic [SW-1:0]   tmr_rm [NUM_TASKS];
	logic [TB-1:0]   wake_new;

	assign slot_req = SW'(req_q.task_id);
	assign tid_ok   = (32'(req_q.task_id) < NUM_TASKS);
	assign req_st   = st_q[slot_req];
	assign head     = rdy_q[0];
	assign rdy_nz   = (rdy_n_q != '0);
	assign ycur     = (req_q.req_type == REQ_TICK) ? rr_q : (req_q.req_type == REQ_YIELD);
	assign settled  = aging_en_q ? base_q[cur_q] : prio_q[cur_q];
	assign preempt  = rdy_nz && (8'(prio_q[head] + {7'b0, ycur}) > prio_q[cur_q]);
	assign block_ok = (cur_q != '0) && rdy_nz;
	assign wake_ok  = tid_ok && (req_st == ST_BLOCKED || req_st == ST_DORMANT);
	assign ready_ok = tid_ok && (req_st == ST_DORMANT);
	assign raise_ok = tid_ok && (prio_q[slot_req] < req_q.new_priority);
	assign wake_new = TB'(32'(counter_q) + 32'(req_q.timeout));

	assign status.req_type  = req_q.req_type;
	assign status.timer_due = (tmr_n_q != '0) && (wake_q[tmr_q[0]] == counter_q);
	assign status.aging_en  = aging_en_q;
	assign status.age_zero  = (agecnt_q == 16'd1);
	assign status.preempt   = preempt;
	assign status.block_ok  = block_ok;
	assign status.requeue   = raise_ok && (req_st == ST_READY);

	assign result.running_task  = 3'(cur_q);
	assign result.switched      = (cur_q != before_q);
	assign result.resume_result = res_q[cur_q];
	assign result.block_refused = refused_q;
	assign result.tick_now      = 16'(counter_q);

	always_comb begin
		case (cmd.op)
			CMD_WAKE_HEAD: begin
				ins_slot = tmr_q[0];
				ins_key  = prio_q[tmr_q[0]];
			end
			CMD_MAKE_READY: begin
				ins_slot = slot_req;
				ins_key  = req_q.new_priority;
			end
			CMD_SCHED_INS: begin
				ins_slot = cur_q;
				ins_key  = 8'(settled + 8'd1 - {7'b0, ycur});
			end
			default: begin
				ins_slot = slot_req;
				ins_key  = prio_q[slot_req];
			end
		endcase
		rm_slot  = (cmd.op == CMD_DISPATCH) ? head : slot_req;
		trm_slot = (cmd.op == CMD_WAKE_HEAD) ? tmr_q[0] : slot_req;
	end

	always_comb begin
		logic ins_found;
		logic rm_found;
		logic tins_found;
		logic trm_found;
		ins_found  = 1'b0;
		rm_found   = 1'b0;
		tins_found = 1'b0;
		trm_found  = 1'b0;
		ins_pos    = rdy_n_q;
		rm_pos     = rdy_n_q;
		tins_pos   = tmr_n_q;
		trm_pos    = tmr_n_q;
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (!ins_found && CW'(i) < rdy_n_q && prio_q[rdy_q[i]] < ins_key) begin
				ins_pos   = CW'(i);
				ins_found = 1'b1;
			end
			if (!rm_found && CW'(i) < rdy_n_q && rdy_q[i] == rm_slot) begin
				rm_pos   = CW'(i);
				rm_found = 1'b1;
			end
			if (!tins_found && CW'(i) < tmr_n_q &&
			    32'(TB'(wake_q[tmr_q[i]] - counter_q)) > 32'(req_q.timeout)) begin
				tins_pos   = CW'(i);
				tins_found = 1'b1;
			end
			if (!trm_found && CW'(i) < tmr_n_q && tmr_q[i] == trm_slot) begin
				trm_pos   = CW'(i);
				trm_found = 1'b1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_TASKS; j++) begin
			if (CW'(j) < ins_pos) begin
				rdy_ins[j] = rdy_q[j];
			end else if (CW'(j) == ins_pos || j == 0) begin
				rdy_ins[j] = ins_slot;
			end else begin
				rdy_ins[j] = rdy_q[j-1];
			end
			if (CW'(j) < tins_pos) begin
				tmr_ins[j] = tmr_q[j];
			end else if (CW'(j) == tins_pos || j == 0) begin
				tmr_ins[j] = cur_q;
			end else begin
				tmr_ins[j] = tmr_q[j-1];
			end
			if (CW'(j) < rm_pos || j + 1 >= NUM_TASKS) begin
				rdy_rm[j] = rdy_q[j];
			end else begin
				rdy_rm[j] = rdy_q[j+1];
			end
			if (CW'(j) < trm_pos || j + 1 >= NUM_TASKS) begin
				tmr_rm[j] = tmr_q[j];
			end else begin
				tmr_rm[j] = tmr_q[j+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_LOAD) begin
			req_q    <= req_in;
			before_q <= cur_q;
		end
		if (cmd.op == CMD_BLOCK && block_ok && req_q.timeout != WAIT_FOREVER) begin
			wake_q[cur_q] <= wake_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_en_q <= 1'b1;
			period_q   <= AGING_PERIOD_RST;
			limit_q    <= AGING_LIMIT_RST;
			rr_q       <= 1'b1;
			refused_q  <= 1'b0;
			cur_q      <= '0;
			counter_q  <= '0;
			agecnt_q   <= AGING_PERIOD_RST;
			rdy_n_q    <= '0;
			tmr_n_q    <= '0;
			for (int t = 0; t < NUM_TASKS; t++) begin
				prio_q[t]  <= '0;
				base_q[t]  <= '0;
				st_q[t]    <= (t == 0) ? ST_RUNNING : ST_DORMANT;
				timed_q[t] <= 1'b0;
				res_q[t]   <= '0;
				rdy_q[t]   <= '0;
				tmr_q[t]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_AGING_EN:     aging_en_q <= cfg_data[0];
					CFG_AGING_PERIOD: period_q   <= cfg_data;
					CFG_AGING_LIMIT:  limit_q    <= cfg_data[7:0];
					CFG_ROUND_ROBIN:  rr_q       <= cfg_data[0];
					CFG_TICK_START:   ;
					default:          ;
				endcase
			end
			case (cmd.op)
				CMD_LOAD: refused_q <= 1'b0;
				CMD_TICK_INC: counter_q <= counter_q + 1'b1;
				CMD_WAKE_HEAD: begin
					res_q[tmr_q[0]]   <= '0;
					st_q[tmr_q[0]]    <= ST_READY;
					timed_q[tmr_q[0]] <= 1'b0;
					tmr_q             <= tmr_rm;
					tmr_n_q           <= tmr_n_q - 1'b1;
					rdy_q             <= rdy_ins;
					rdy_n_q           <= rdy_n_q + 1'b1;
				end
				CMD_AGE_SETTLE: begin
					prio_q[cur_q] <= base_q[cur_q];
					agecnt_q      <= (agecnt_q == 16'd1) ? period_q : agecnt_q - 16'd1;
				end
				CMD_AGE_PASS: begin
					for (int t = 0; t < NUM_TASKS; t++) begin
						if (st_q[t] == ST_READY && prio_q[t] != '0 && prio_q[t] < limit_q &&
						    {1'b0, prio_q[t]} + {8'b0, rr_q} <= {1'b0, prio_q[cur_q]}) begin
							prio_q[t] <= prio_q[t] + 8'd1;
						end
					end
				end
				CMD_SCHED_INS: begin
					if (preempt) begin
						prio_q[cur_q]  <= settled;
						st_q[cur_q]    <= ST_READY;
						timed_q[cur_q] <= 1'b0;
						rdy_q          <= rdy_ins;
						rdy_n_q        <= rdy_n_q + 1'b1;
					end
				end
				CMD_DISPATCH: begin
					if (rdy_nz) begin
						cur_q         <= head;
						st_q[head]    <= ST_RUNNING;
						timed_q[head] <= 1'b0;
						rdy_q         <= rdy_rm;
						rdy_n_q       <= rdy_n_q - 1'b1;
					end
				end
				CMD_BLOCK: begin
					if (block_ok) begin
						prio_q[cur_q] <= settled;
						st_q[cur_q]   <= ST_BLOCKED;
						if (req_q.timeout != WAIT_FOREVER) begin
							timed_q[cur_q] <= 1'b1;
							tmr_q          <= tmr_ins;
							tmr_n_q        <= tmr_n_q + 1'b1;
						end
					end else begin
						refused_q <= 1'b1;
					end
				end
				CMD_WAKE: begin
					if (wake_ok) begin
						res_q[slot_req]   <= req_q.wake_result;
						st_q[slot_req]    <= ST_READY;
						timed_q[slot_req] <= 1'b0;
						if (timed_q[slot_req]) begin
							tmr_q   <= tmr_rm;
							tmr_n_q <= tmr_n_q - 1'b1;
						end
						rdy_q   <= rdy_ins;
						rdy_n_q <= rdy_n_q + 1'b1;
					end
				end
				CMD_MAKE_READY: begin
					if (ready_ok) begin
						prio_q[slot_req]  <= req_q.new_priority;
						base_q[slot_req]  <= req_q.new_priority;
						st_q[slot_req]    <= ST_READY;
						timed_q[slot_req] <= 1'b0;
						rdy_q             <= rdy_ins;
						rdy_n_q           <= rdy_n_q + 1'b1;
					end
				end
				CMD_RAISE: begin
					if (raise_ok) begin
						prio_q[slot_req] <= req_q.new_priority;
						if (req_st == ST_READY) begin
							rdy_q   <= rdy_rm;
							rdy_n_q <= rdy_n_q - 1'b1;
						end
					end
				end
				CMD_RQ_INS: begin
					rdy_q   <= rdy_ins;
					rdy_n_q <= rdy_n_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule
